[hw/rtl/spectrum_to_rgb_pixel_defines.svh]
// Assertion macros used by the spectrum-to-RGB RTL.
`ifndef SPECTRUM_TO_RGB_PIXEL_DEFINES_SVH
`define SPECTRUM_TO_RGB_PIXEL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define S2R_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2r assertion failed");

// Next-cycle implication, checked out of reset.
`define S2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2r assertion failed");

`endif

[hw/rtl/s2r_pkg.sv]
// Types, constants and colour-match table for the spectrum-to-RGB block.
`default_nettype none
package s2r_pkg;

  localparam int TABLE_ROWS  = 81;
  localparam int POWER_BITS  = 16;
  localparam int ROW_W       = 7;
  localparam int CMF_W       = 15;
  localparam int ACC_W       = 40;
  localparam int PWR_W       = 24;
  localparam int DATA_W      = 64;

  // configuration register indexes
  localparam logic [2:0] REG_RED_X   = 3'd0;
  localparam logic [2:0] REG_RED_Y   = 3'd1;
  localparam logic [2:0] REG_GREEN_X = 3'd2;
  localparam logic [2:0] REG_GREEN_Y = 3'd3;
  localparam logic [2:0] REG_BLUE_X  = 3'd4;
  localparam logic [2:0] REG_BLUE_Y  = 3'd5;
  localparam logic [2:0] REG_WHITE_X = 3'd6;
  localparam logic [2:0] REG_WHITE_Y = 3'd7;

  localparam logic [15:0] RST_RED_X   = 16'd48201;
  localparam logic [15:0] RST_RED_Y   = 16'd17334;
  localparam logic [15:0] RST_GREEN_X = 16'd17419;
  localparam logic [15:0] RST_GREEN_Y = 16'd47468;
  localparam logic [15:0] RST_BLUE_X  = 16'd10938;
  localparam logic [15:0] RST_BLUE_Y  = 16'd557;
  localparam logic [15:0] RST_WHITE_X = 16'd21845;
  localparam logic [15:0] RST_WHITE_Y = 16'd21845;

  // shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic [6:0]  band_index;
    logic [15:0] sample_power;
    logic        last_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       no_energy;
  } out_t;

  typedef struct packed {
    logic [CMF_W-1:0] x;
    logic [CMF_W-1:0] y;
    logic [CMF_W-1:0] z;
  } cmf_row_t;

  typedef struct packed {
    logic              start;
    logic              op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } mdu_rsp_t;

  localparam int CMF_X [TABLE_ROWS] = '{
    23, 36, 69, 125, 234, 380, 713, 1271, 2202, 3519, 4651, 5382, 5707, 5703,
    5508, 5222, 4764, 4114, 3201, 2328, 1566, 950, 524, 241, 80, 39, 152, 477,
    1037, 1796, 2712, 3698, 4758, 5893, 7101, 8390, 9740, 11115, 12486, 13804,
    15013, 16033, 16815, 17313, 17403, 17131, 16427, 15375, 13998, 12311,
    10525, 8878, 7338, 5911, 4645, 3583, 2702, 1986, 1432, 1042, 767, 539,
    372, 259, 187, 133, 95, 67, 48, 33, 23, 16, 11, 8, 5, 3, 3, 2, 2, 2, 0
  };

  localparam int CMF_Y [TABLE_ROWS] = '{
    0, 2, 2, 3, 7, 10, 20, 36, 66, 120, 190, 275, 377, 488, 623, 786, 983,
    1211, 1491, 1845, 2277, 2774, 3408, 4237, 5292, 6673, 8241, 9965, 11633,
    12996, 14123, 14990, 15630, 16061, 16302, 16384, 16302, 16033, 15598,
    14998, 14254, 13374, 12403, 11385, 10338, 9286, 8241, 7229, 6242, 5259,
    4342, 3555, 2867, 2264, 1753, 1337, 999, 731, 524, 380, 279, 195, 134, 93,
    67, 48, 34, 25, 16, 11, 8, 7, 3, 3, 2, 2, 2, 0, 0, 0, 0
  };

  localparam int CMF_Z [TABLE_ROWS] = '{
    106, 172, 329, 593, 1112, 1806, 3398, 6083, 10578, 17025, 22702, 26591,
    28624, 29206, 29034, 28575, 27348, 25036, 21096, 17070, 13320, 10096,
    7622, 5788, 4456, 3478, 2592, 1830, 1281, 939, 691, 488, 333, 220, 143,
    93, 64, 44, 34, 29, 28, 23, 18, 16, 13, 10, 5, 3, 3, 2, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // bands past the table read the all-zero last row
  function automatic cmf_row_t cmf_lookup(input logic [ROW_W-1:0] band);
    logic [ROW_W-1:0] row;
    cmf_row_t         r;
    row = (band < ROW_W'(TABLE_ROWS)) ? band : ROW_W'(TABLE_ROWS - 1);
    r.x = CMF_W'(CMF_X[row]);
    r.y = CMF_W'(CMF_Y[row]);
    r.z = CMF_W'(CMF_Z[row]);
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/s2r_muldiv.sv]
// Shared signed multiply / divide unit, shift-add and restoring, one bit a cycle.
`default_nettype none
module s2r_muldiv (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire s2r_pkg::mdu_req_t  req,
  output s2r_pkg::mdu_rsp_t       rsp
);

  localparam int W = s2r_pkg::DATA_W;

  logic         busy_r;
  logic         done_r;
  logic         op_r;
  logic         neg_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] x_r;
  logic [W-1:0] y_r;
  logic [W-1:0] rem_r;
  logic [$clog2(W)-1:0] cnt_r;

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W-1:0] rem_sh;
  logic [W:0]   add_a;
  logic [W:0]   add_b;
  logic [W:0]   sum;

  assign mag_a  = req.a[W-1] ? (~req.a + W'(1)) : req.a;
  assign mag_b  = req.b[W-1] ? (~req.b + W'(1)) : req.b;
  assign rem_sh = {rem_r[W-2:0], x_r[W-1]};

  // one adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (op_r == s2r_pkg::OP_DIV) begin
      add_a = {1'b0, rem_sh};
      add_b = {1'b0, ~y_r};
    end else begin
      add_a = {1'b0, acc_r};
      add_b = {1'b0, x_r};
    end
    sum = add_a + add_b + {{W{1'b0}}, op_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        neg_r  <= req.a[W-1] ^ req.b[W-1];
        x_r    <= mag_a;
        y_r    <= mag_b;
        acc_r  <= '0;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (op_r == s2r_pkg::OP_DIV) begin
          // carry out set means the shifted remainder covers the divisor
          rem_r <= sum[W] ? sum[W-1:0] : rem_sh;
          acc_r <= {acc_r[W-2:0], sum[W]};
          x_r   <= {x_r[W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          if (y_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            if (y_r[0]) acc_r <= sum[W-1:0];
            x_r <= {x_r[W-2:0], 1'b0};
            y_r <= {1'b0, y_r[W-1:1]};
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = neg_r ? (~acc_r + W'(1)) : acc_r;

endmodule
`default_nettype wire

[hw/rtl/spectrum_to_rgb_pixel.sv]
// Spectrum-to-RGB pixel: accumulates CIE-weighted samples, converts to RGB bytes.
// A sample that is not last is accepted and ready stays high.
// A last sample holds the input while the pixel is converted (none of this for a black pixel): 15 divides
// and 39 multiplies at most, one at a time in the one shared multiply/divide unit.
// Results wait in an output register, so samples of the next pixel may enter meanwhile.
// Synchronous active-low reset clears sums, state and output valid; registers load defaults.
`default_nettype none
`include "spectrum_to_rgb_pixel_defines.svh"
module spectrum_to_rgb_pixel #(
  parameter int POWER_BITS = s2r_pkg::POWER_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire s2r_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output s2r_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);

  localparam int PW    = (POWER_BITS < 16) ? POWER_BITS : 16;
  localparam int ACC_W = s2r_pkg::ACC_W;
  localparam int PWR_W = s2r_pkg::PWR_W;
  localparam int W     = s2r_pkg::DATA_W;
  localparam int S_W   = ACC_W + 2;
  localparam int C_W   = 36;
  localparam int WW    = 56;
  localparam int CH_W  = 50;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_NDIV = 4'd2;
  localparam logic [3:0] ST_NMUL = 4'd3;
  localparam logic [3:0] ST_CF1  = 4'd4;
  localparam logic [3:0] ST_CF2  = 4'd5;
  localparam logic [3:0] ST_WMUL = 4'd6;
  localparam logic [3:0] ST_WDIV = 4'd7;
  localparam logic [3:0] ST_MDIV = 4'd8;
  localparam logic [3:0] ST_MMUL = 4'd9;
  localparam logic [3:0] ST_BYTE = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam logic [1:0] CO_X = 2'd0;
  localparam logic [1:0] CO_Y = 2'd1;
  localparam logic [1:0] CO_Z = 2'd2;

  logic [15:0] red_x_r, red_y_r, green_x_r, green_y_r;
  logic [15:0] blue_x_r, blue_y_r, white_x_r, white_y_r;

  logic [ACC_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [PWR_W-1:0] sum_power_r;

  logic [3:0]        st_r;
  logic              go_r;
  logic [1:0]        k_r;
  logic [1:0]        j_r;
  logic              blk_r;
  logic [S_W-1:0]    s_r;
  logic [17:0]       q_r;
  logic [31:0]       n_r [3];
  logic signed [C_W-1:0]  c_r [3];
  logic signed [C_W-1:0]  tmp_r;
  logic signed [WW-1:0]   wacc_r;
  logic signed [WW-1:0]   w_r;
  logic signed [31:0]     m_r;
  logic signed [CH_W-1:0] ch_r;
  logic [7:0]        rgb_r [3];
  logic              out_valid_r;
  s2r_pkg::out_t     out_data_r;

  s2r_pkg::mdu_req_t req;
  s2r_pkg::mdu_rsp_t rsp;

  s2r_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // ---------------- accumulation ----------------
  s2r_pkg::cmf_row_t cmf;
  logic [15:0]      power;
  logic [30:0]      px_w, py_w, pz_w;
  logic [ACC_W:0]   ax, ay, az;
  logic [PWR_W:0]   ap;
  logic             in_acc;
  logic             out_load;

  assign cmf   = s2r_pkg::cmf_lookup(in_data.band_index);
  assign power = in_data.sample_power & 16'((17'd1 << PW) - 17'd1);
  assign px_w  = 31'(power) * 31'(cmf.x);
  assign py_w  = 31'(power) * 31'(cmf.y);
  assign pz_w  = 31'(power) * 31'(cmf.z);
  assign ax    = {1'b0, sum_x_r} + (ACC_W + 1)'(px_w);
  assign ay    = {1'b0, sum_y_r} + (ACC_W + 1)'(py_w);
  assign az    = {1'b0, sum_z_r} + (ACC_W + 1)'(pz_w);
  assign ap    = {1'b0, sum_power_r} + (PWR_W + 1)'(power);

  assign in_ready  = (st_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (st_r == ST_OUT) && (!out_valid_r || out_ready);

  // ---------------- operand selection ----------------
  logic signed [17:0] wx, wy, wz;
  logic [1:0]         ia, ib;
  logic [1:0]         co1, co2;
  logic [1:0]         i1, i2;
  logic [ACC_W-1:0]   v_sel;
  logic [57:0]        v_tri;
  logic [S_W-1:0]     s_sum;

  assign wx = 18'(white_x_r);
  assign wy = (white_y_r == 16'd0) ? 18'sd1 : 18'(white_y_r);
  assign wz = 18'sd65536 - wx - wy;
  assign ia = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
  assign ib = (k_r == 2'd0) ? 2'd2 : k_r - 2'd1;
  assign s_sum = S_W'(sum_x_r) + S_W'(sum_y_r) + S_W'(sum_z_r);

  function automatic logic signed [17:0] coord(input logic [1:0] co, input logic [1:0] idx,
      input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] gx,
      input logic [15:0] gy, input logic [15:0] bx, input logic [15:0] by);
    logic signed [17:0] x, y;
    case (idx)
      2'd0:    begin x = 18'(rx); y = 18'(ry); end
      2'd1:    begin x = 18'(gx); y = 18'(gy); end
      default: begin x = 18'(bx); y = 18'(by); end
    endcase
    case (co)
      CO_X:    return x;
      CO_Y:    return y;
      default: return 18'sd65536 - x - y;
    endcase
  endfunction

  always_comb begin
    // coordinate pair and row order of each cofactor's two products
    unique case (j_r)
      2'd0:    begin co1 = CO_Y; co2 = CO_Z; i1 = ia; i2 = ib; end
      2'd1:    begin co1 = CO_X; co2 = CO_Z; i1 = ib; i2 = ia; end
      default: begin co1 = CO_X; co2 = CO_Y; i1 = ia; i2 = ib; end
    endcase
    if (st_r == ST_CF2) begin
      i1 = (i1 == ia) ? ib : ia;
      i2 = (i2 == ia) ? ib : ia;
    end
    unique case (j_r)
      2'd0:    v_sel = sum_x_r;
      2'd1:    v_sel = sum_y_r;
      default: v_sel = sum_z_r;
    endcase
    v_tri = {2'b0, v_sel, 16'b0} + {1'b0, v_sel, 17'b0};
  end

  logic signed [17:0] wsel;
  always_comb begin
    unique case (j_r)
      2'd0:    wsel = wx;
      2'd1:    wsel = wy;
      default: wsel = wz;
    endcase
  end

  always_comb begin
    req.start = !go_r && (st_r != ST_IDLE) && (st_r != ST_SUM) &&
                (st_r != ST_BYTE) && (st_r != ST_OUT);
    req.op    = s2r_pkg::OP_MUL;
    req.a     = '0;
    req.b     = '0;
    unique case (st_r)
      ST_NDIV: begin
        req.op = s2r_pkg::OP_DIV;
        req.a  = W'(v_tri);
        req.b  = W'(s_r);
      end
      ST_NMUL: begin
        req.a = W'(q_r);
        req.b = W'(sum_power_r);
      end
      ST_CF1, ST_CF2: begin
        req.a = W'(coord(co1, i1, red_x_r, red_y_r, green_x_r, green_y_r,
                         blue_x_r, blue_y_r));
        req.b = W'(coord(co2, i2, red_x_r, red_y_r, green_x_r, green_y_r,
                         blue_x_r, blue_y_r));
      end
      ST_WMUL: begin
        req.a = W'(c_r[j_r]);
        req.b = W'(wsel);
      end
      ST_WDIV: begin
        req.op = s2r_pkg::OP_DIV;
        req.a  = W'(wacc_r);
        req.b  = W'(wy);
      end
      ST_MDIV: begin
        req.op = s2r_pkg::OP_DIV;
        req.a  = W'(c_r[j_r]) <<< 16;
        req.b  = W'(w_r);
      end
      ST_MMUL: begin
        req.a = W'(m_r);
        req.b = W'(n_r[j_r]);
      end
      default: ;
    endcase
  end

  // ---------------- result shaping ----------------
  logic signed [W-1:0]    res_s;
  logic signed [31:0]     m_sat;
  logic signed [W-1:0]    t_rnd;
  logic signed [CH_W-1:0] t_q16;
  logic [CH_W+7:0]        ch255;
  logic [7:0]             byte_v;

  assign res_s = rsp.res;
  assign m_sat = (res_s > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (res_s < -64'sh8000_0000) ? 32'sh8000_0000 : res_s[31:0];
  // truncate toward zero on the divide by 65536
  assign t_rnd = res_s[W-1] ? (res_s + 64'sd65535) : res_s;
  assign t_q16 = CH_W'(t_rnd >>> 16);
  assign ch255 = {ch_r, 8'b0} - (CH_W + 8)'(unsigned'(ch_r));
  assign byte_v = (ch_r <= 0) ? 8'd0 :
                  (ch255[CH_W+7:16] > (CH_W - 8)'(255)) ? 8'd255 : ch255[23:16];

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_x_r   <= s2r_pkg::RST_RED_X;
      red_y_r   <= s2r_pkg::RST_RED_Y;
      green_x_r <= s2r_pkg::RST_GREEN_X;
      green_y_r <= s2r_pkg::RST_GREEN_Y;
      blue_x_r  <= s2r_pkg::RST_BLUE_X;
      blue_y_r  <= s2r_pkg::RST_BLUE_Y;
      white_x_r <= s2r_pkg::RST_WHITE_X;
      white_y_r <= s2r_pkg::RST_WHITE_Y;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        s2r_pkg::REG_RED_X:   red_x_r   <= cfg_data;
        s2r_pkg::REG_RED_Y:   red_y_r   <= cfg_data;
        s2r_pkg::REG_GREEN_X: green_x_r <= cfg_data;
        s2r_pkg::REG_GREEN_Y: green_y_r <= cfg_data;
        s2r_pkg::REG_BLUE_X:  blue_x_r  <= cfg_data;
        s2r_pkg::REG_BLUE_Y:  blue_y_r  <= cfg_data;
        s2r_pkg::REG_WHITE_X: white_x_r <= cfg_data;
        s2r_pkg::REG_WHITE_Y: white_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      sum_power_r <= '0;
      st_r        <= ST_IDLE;
      go_r        <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (req.start) go_r <= 1'b1;
      if (rsp.done) go_r <= 1'b0;

      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            sum_x_r     <= ax[ACC_W] ? '1 : ax[ACC_W-1:0];
            sum_y_r     <= ay[ACC_W] ? '1 : ay[ACC_W-1:0];
            sum_z_r     <= az[ACC_W] ? '1 : az[ACC_W-1:0];
            sum_power_r <= ap[PWR_W] ? '1 : ap[PWR_W-1:0];
            if (in_data.last_sample) st_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          s_r <= s_sum;
          j_r <= '0;
          k_r <= '0;
          if (sum_power_r == '0 || s_sum == '0) begin
            blk_r <= 1'b1;
            for (int i = 0; i < 3; i++) rgb_r[i] <= '0;
            st_r <= ST_OUT;
          end else begin
            blk_r <= 1'b0;
            st_r  <= ST_NDIV;
          end
        end
        ST_NDIV: if (rsp.done) begin
          q_r  <= res_s[17:0];
          st_r <= ST_NMUL;
        end
        ST_NMUL: if (rsp.done) begin
          n_r[j_r] <= (res_s > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : res_s[31:0];
          if (j_r == 2'd2) begin
            j_r  <= '0;
            st_r <= ST_CF1;
          end else begin
            j_r  <= j_r + 2'd1;
            st_r <= ST_NDIV;
          end
        end
        ST_CF1: if (rsp.done) begin
          tmp_r <= res_s[C_W-1:0];
          st_r  <= ST_CF2;
        end
        ST_CF2: if (rsp.done) begin
          c_r[j_r] <= tmp_r - res_s[C_W-1:0];
          if (j_r == 2'd2) begin
            j_r    <= '0;
            wacc_r <= '0;
            st_r   <= ST_WMUL;
          end else begin
            j_r  <= j_r + 2'd1;
            st_r <= ST_CF1;
          end
        end
        ST_WMUL: if (rsp.done) begin
          wacc_r <= wacc_r + res_s[WW-1:0];
          if (j_r == 2'd2) begin
            j_r  <= '0;
            st_r <= ST_WDIV;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        ST_WDIV: if (rsp.done) begin
          w_r  <= res_s[WW-1:0];
          ch_r <= '0;
          // a zero white scale leaves the channel black
          st_r <= (res_s == '0) ? ST_BYTE : ST_MDIV;
        end
        ST_MDIV: if (rsp.done) begin
          m_r  <= m_sat;
          st_r <= ST_MMUL;
        end
        ST_MMUL: if (rsp.done) begin
          ch_r <= ch_r + t_q16;
          if (j_r == 2'd2) begin
            j_r  <= '0;
            st_r <= ST_BYTE;
          end else begin
            j_r  <= j_r + 2'd1;
            st_r <= ST_MDIV;
          end
        end
        ST_BYTE: begin
          rgb_r[k_r] <= byte_v;
          j_r        <= '0;
          if (k_r == 2'd2) begin
            st_r <= ST_OUT;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= ST_CF1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            sum_z_r     <= '0;
            sum_power_r <= '0;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.red       <= rgb_r[0];
      out_data_r.green     <= rgb_r[1];
      out_data_r.blue      <= rgb_r[2];
      out_data_r.no_energy <= blk_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `S2R_ASSERT_IMPL(a_done_issued, rsp.done, go_r)
  `S2R_ASSERT_NEXT(a_last_starts, in_acc && in_data.last_sample, st_r == ST_SUM)
  `S2R_ASSERT_IMPL(a_black_flag, out_valid && out_data.no_energy,
                   out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
  `S2R_ASSERT_NEXT(a_sums_cleared, out_load, sum_power_r == '0 && sum_x_r == '0)

endmodule
`default_nettype wire
